### rtl/tcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, register codes, reset values and the CORDIC arctangent table
// of the tilt complementary filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

	// payload types
	typedef logic signed [15:0] sample_t;
	typedef logic signed [15:0] roll_t;
	typedef logic signed [14:0] pitch_t;
	typedef logic signed [15:0] fused_t;

	// default parameter values
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;

	// configuration port
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_SEL_W = 2;

	typedef enum logic [REG_SEL_W-1:0] {
		REG_BLEND_WEIGHT = 2'd0,
		REG_TIME_STEP    = 2'd1,
		REG_GYRO_GAIN    = 2'd2
	} reg_idx_t;

	localparam logic [15:0] BLEND_WEIGHT_RST = 16'd52429;
	localparam logic [15:0] TIME_STEP_RST    = 16'd760;
	localparam logic [23:0] GYRO_GAIN_RST    = 24'd65536;

	// arithmetic constants
	localparam int ANGLE_180_Q16 = 180 * 65536;
	localparam int SQRT_STEPS    = 32;
	localparam int MUL_A_W       = 18;
	localparam int MUL_B_W       = 25;
	localparam int ATAN_IDX_W    = 5;
	localparam int ATAN_W        = 22;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_ADD,
		ST_ROOT,
		ST_PITCH_INIT,
		ST_PITCH,
		ST_GAIN,
		ST_RATE_LO,
		ST_RATE_HI,
		ST_RATE_SUM,
		ST_PRED,
		ST_W_LO,
		ST_W_HI,
		ST_W_PITCH,
		ST_PITCH_ADD,
		ST_OUT
	} state_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/tcf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_in_if
// Valid/ready channel carrying one raw inertial sample.
// ----------------------------------------------------------------------------
interface tcf_in_if;
	logic             valid;
	logic             ready;
	tcf_pkg::sample_t accel_x;
	tcf_pkg::sample_t accel_y;
	tcf_pkg::sample_t accel_z;
	tcf_pkg::sample_t turn_rate;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		output turn_rate, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		input turn_rate, output ready);
endinterface
`default_nettype wire

### rtl/tcf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_out_if
// Valid/ready channel carrying roll, pitch and the filtered angle.
// ----------------------------------------------------------------------------
interface tcf_out_if;
	logic            valid;
	logic            ready;
	tcf_pkg::roll_t  roll_angle;
	tcf_pkg::pitch_t pitch_angle;
	tcf_pkg::fused_t fused_angle;

	modport source (output valid, output roll_angle, output pitch_angle,
		output fused_angle, input ready);
	modport sink (input valid, input roll_angle, input pitch_angle,
		input fused_angle, output ready);
endinterface
`default_nettype wire

### rtl/tilt_complementary_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Roll and pitch from the accelerometer by a vectoring CORDIC, pitch fused
// with the integrated gyro rate by a complementary filter.
//
//   channel   dir  transaction                     payload
//   sample    in   valid && ready                  accel_x/y/z, turn_rate
//   angles    out  valid && ready                  roll, pitch, fused angle
//   apb       in   psel && penable && pwrite       blend_weight, time_step,
//                                                  gyro_gain at 0x0/0x4/0x8
//
// The 32-step square-root recurrence and the pitch CORDIC that waits on its
// result set the time from one acceptance to the earliest next one; the roll
// CORDIC runs beside the root. A zero accel_x skips the pitch micro-rotations.
// The result sits in an output register, so a new sample is taken while it
// waits; only the final write stalls on a full output register.
// Reset is asynchronous, no clearing pass is needed.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
	parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tcf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tcf_pkg::DATA_W-1:0] pwdata,
	output logic      [tcf_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	tcf_in_if.sink                          sample,
	tcf_out_if.source                       angles
);

	// derived widths and constants
	localparam int XY_W      = 36;
	localparam int Z_W       = 27;
	localparam int CNT_W     = $clog2(CORDIC_STEPS + 1);
	localparam int STEP_W    = $clog2(tcf_pkg::SQRT_STEPS);
	localparam int REM_W     = 36;
	localparam int PROD_W    = tcf_pkg::MUL_A_W + tcf_pkg::MUL_B_W;
	localparam int LSB_SHIFT = 16 - ANGLE_FRAC_BITS;
	localparam int LSB_RND   = 1 << (LSB_SHIFT - 1);
	localparam int SUM_W     = 42 + ANGLE_FRAC_BITS;
	localparam int ACC_W     = SUM_W + 17;
	localparam int RES_W     = ACC_W - 32;

	localparam logic signed [Z_W-1:0]   Z_180     = Z_W'(tcf_pkg::ANGLE_180_Q16);
	localparam logic signed [15:0]      ROLL_LIM  = 16'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [15:0]      PITCH_LIM = 16'(90 << ANGLE_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] ACC_RND   = {{(ACC_W-32){1'b0}}, 1'b1, 31'd0};
	localparam logic signed [RES_W-1:0] RES_MAX   = RES_W'(32'sd32767);
	localparam logic signed [RES_W-1:0] RES_MIN   = RES_W'(-32'sd32768);

	// round a Q16 angle to the output lsb and clamp it
	function automatic logic signed [15:0] to_lsb(input logic signed [Z_W-1:0] z,
		input logic signed [15:0] lim);
		logic signed [Z_W:0] r;
		r = ((Z_W+1)'(z) + (Z_W+1)'(LSB_RND)) >>> LSB_SHIFT;
		if (r > lim)
			r = (Z_W+1)'(lim);
		if (r < -lim)
			r = -(Z_W+1)'(lim);
		return 16'(r);
	endfunction

	tcf_pkg::state_t state_q, state_d;

	logic sample_ready;
	logic sample_fire;
	logic out_load;

	// configuration registers
	logic [15:0] blend_weight_q;
	logic [15:0] time_step_q;
	logic [23:0] gyro_gain_q;
	logic [tcf_pkg::REG_SEL_W-1:0] reg_sel;
	logic cfg_write;

	// captured sample
	tcf_pkg::sample_t ax_q, ay_q, az_q, rate_q;

	// shared multiplier and accumulator
	logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [tcf_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]           prod_s1;
	logic signed [ACC_W-1:0]            acc_q;
	logic [15:0]                        ph_q;
	logic [17:0]                        inv_w;

	// square root
	logic [31:0]       sq_src_q;
	logic [REM_W-1:0]  sq_rem_q;
	logic [31:0]       sq_root_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0]       sq_sum;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              rem_ge;

	// cordic
	logic signed [XY_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]  cz_q;
	logic [CNT_W-1:0]       ccnt_q;
	logic                   cordic_load;
	logic                   cordic_run;
	logic signed [XY_W-1:0] ld_x, ld_y, ld_xs, ld_ys;
	logic signed [Z_W-1:0]  ld_z;
	logic                   ld_hold;
	logic signed [XY_W-1:0] x_shift, y_shift;
	logic signed [Z_W-1:0]  at_step;

	// results
	tcf_pkg::roll_t  roll_q;
	tcf_pkg::pitch_t pitch_q;
	tcf_pkg::fused_t filt_q;
	tcf_pkg::fused_t fused_sat;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [RES_W-1:0] res_wide;
	logic out_valid_q;
	tcf_pkg::roll_t  out_roll_q;
	tcf_pkg::pitch_t out_pitch_q;
	tcf_pkg::fused_t out_fused_q;

	// apb register file
	assign pready    = 1'b1;
	assign reg_sel   = paddr[tcf_pkg::ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q <= tcf_pkg::BLEND_WEIGHT_RST;
			time_step_q    <= tcf_pkg::TIME_STEP_RST;
			gyro_gain_q    <= tcf_pkg::GYRO_GAIN_RST;
		end else if (cfg_write) begin
			unique case (reg_sel)
				tcf_pkg::REG_BLEND_WEIGHT: blend_weight_q <= pwdata[15:0];
				tcf_pkg::REG_TIME_STEP:    time_step_q    <= pwdata[15:0];
				tcf_pkg::REG_GYRO_GAIN:    gyro_gain_q    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tcf_pkg::REG_BLEND_WEIGHT: prdata = {16'd0, blend_weight_q};
			tcf_pkg::REG_TIME_STEP:    prdata = {16'd0, time_step_q};
			tcf_pkg::REG_GYRO_GAIN:    prdata = {8'd0, gyro_gain_q};
			default:                   prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tcf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			tcf_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample.valid)
					state_d = tcf_pkg::ST_SQ_Y;
			end
			tcf_pkg::ST_SQ_Y:       state_d = tcf_pkg::ST_SQ_Z;
			tcf_pkg::ST_SQ_Z:       state_d = tcf_pkg::ST_SQ_ADD;
			tcf_pkg::ST_SQ_ADD:     state_d = tcf_pkg::ST_ROOT;
			tcf_pkg::ST_ROOT: begin
				if (step_q == STEP_W'(tcf_pkg::SQRT_STEPS - 1))
					state_d = tcf_pkg::ST_PITCH_INIT;
			end
			tcf_pkg::ST_PITCH_INIT: state_d = tcf_pkg::ST_PITCH;
			tcf_pkg::ST_PITCH: begin
				if (!cordic_run)
					state_d = tcf_pkg::ST_GAIN;
			end
			tcf_pkg::ST_GAIN:       state_d = tcf_pkg::ST_RATE_LO;
			tcf_pkg::ST_RATE_LO:    state_d = tcf_pkg::ST_RATE_HI;
			tcf_pkg::ST_RATE_HI:    state_d = tcf_pkg::ST_RATE_SUM;
			tcf_pkg::ST_RATE_SUM:   state_d = tcf_pkg::ST_PRED;
			tcf_pkg::ST_PRED:       state_d = tcf_pkg::ST_W_LO;
			tcf_pkg::ST_W_LO:       state_d = tcf_pkg::ST_W_HI;
			tcf_pkg::ST_W_HI:       state_d = tcf_pkg::ST_W_PITCH;
			tcf_pkg::ST_W_PITCH:    state_d = tcf_pkg::ST_PITCH_ADD;
			tcf_pkg::ST_PITCH_ADD:  state_d = tcf_pkg::ST_OUT;
			tcf_pkg::ST_OUT: begin
				if (!out_valid_q || angles.ready) begin
					out_load = 1'b1;
					state_d  = tcf_pkg::ST_IDLE;
				end
			end
			default: state_d = tcf_pkg::ST_IDLE;
		endcase
	end

	assign sample.ready = sample_ready;
	assign sample_fire  = sample.valid && sample_ready;

	// multiplier operand select
	assign inv_w = 18'h10000 - {2'b00, blend_weight_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			tcf_pkg::ST_SQ_Y: begin
				mul_a = tcf_pkg::MUL_A_W'(ay_q);
				mul_b = tcf_pkg::MUL_B_W'(ay_q);
			end
			tcf_pkg::ST_SQ_Z: begin
				mul_a = tcf_pkg::MUL_A_W'(az_q);
				mul_b = tcf_pkg::MUL_B_W'(az_q);
			end
			tcf_pkg::ST_GAIN: begin
				mul_a = {2'b00, time_step_q};
				mul_b = {1'b0, gyro_gain_q};
			end
			tcf_pkg::ST_RATE_LO: begin
				mul_a = tcf_pkg::MUL_A_W'(rate_q);
				mul_b = {1'b0, prod_s1[23:0]};
			end
			tcf_pkg::ST_RATE_HI: begin
				mul_a = tcf_pkg::MUL_A_W'(rate_q);
				mul_b = {9'd0, ph_q};
			end
			tcf_pkg::ST_W_LO: begin
				mul_a = {2'b00, blend_weight_q};
				mul_b = {1'b0, acc_q[23:0]};
			end
			tcf_pkg::ST_W_HI: begin
				mul_a = {2'b00, blend_weight_q};
				mul_b = tcf_pkg::MUL_B_W'(signed'(acc_q[SUM_W-1:24]));
			end
			tcf_pkg::ST_W_PITCH: begin
				mul_a = inv_w;
				mul_b = tcf_pkg::MUL_B_W'(pitch_q);
			end
			default: ;
		endcase
	end

	// square-root digit step, two radicand bits per cycle
	assign sq_sum = acc_q[31:0] + prod_s1[31:0];
	assign rem_sh = {sq_rem_q[REM_W-3:0], sq_src_q[31:30]};
	assign trial  = REM_W'({sq_root_q, 2'b01});
	assign rem_ge = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (state_q == tcf_pkg::ST_SQ_ADD)
			step_q <= '0;
		else if (state_q == tcf_pkg::ST_ROOT)
			step_q <= step_q + 1'b1;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (sample_fire) begin
			ax_q   <= sample.accel_x;
			ay_q   <= sample.accel_y;
			az_q   <= sample.accel_z;
			rate_q <= sample.turn_rate;
		end
		unique case (state_q)
			tcf_pkg::ST_SQ_Z: acc_q <= ACC_W'(prod_s1);
			tcf_pkg::ST_SQ_ADD: begin
				sq_src_q  <= sq_sum;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			tcf_pkg::ST_ROOT: begin
				sq_src_q <= {sq_src_q[29:0], 2'b00};
				if (rem_ge) begin
					sq_rem_q  <= rem_sh - trial;
					sq_root_q <= {sq_root_q[30:0], 1'b1};
				end else begin
					sq_rem_q  <= rem_sh;
					sq_root_q <= {sq_root_q[30:0], 1'b0};
				end
			end
			tcf_pkg::ST_PITCH_INIT: roll_q  <= to_lsb(cz_q, ROLL_LIM);
			tcf_pkg::ST_GAIN:       pitch_q <= 15'(to_lsb(cz_q, PITCH_LIM));
			tcf_pkg::ST_RATE_LO:    ph_q    <= prod_s1[39:24];
			tcf_pkg::ST_RATE_HI:    acc_q   <= ACC_W'(prod_s1);
			tcf_pkg::ST_RATE_SUM:   acc_q   <= acc_q + (ACC_W'(prod_s1) <<< 24);
			// gyro prediction: stored angle plus truncated increment
			tcf_pkg::ST_PRED:
				acc_q <= (ACC_W'(filt_q) <<< 16) + (acc_q >>> LSB_SHIFT);
			tcf_pkg::ST_W_HI:       acc_q   <= ACC_W'(prod_s1);
			tcf_pkg::ST_W_PITCH:    acc_q   <= acc_q + (ACC_W'(prod_s1) <<< 24);
			tcf_pkg::ST_PITCH_ADD:  acc_q   <= acc_q + (ACC_W'(prod_s1) <<< 16);
			default: ;
		endcase
	end

	// cordic start vector: zero numerator and left half-plane folding
	assign cordic_load = sample_fire || (state_q == tcf_pkg::ST_PITCH_INIT);
	assign cordic_run  = (ccnt_q != CNT_W'(CORDIC_STEPS));

	always_comb begin
		if (state_q == tcf_pkg::ST_IDLE) begin
			ld_y = XY_W'(sample.accel_y) <<< 16;
			ld_x = XY_W'(sample.accel_z) <<< 16;
		end else begin
			ld_y = -(XY_W'(ax_q) <<< 16);
			ld_x = XY_W'(sq_root_q);
		end
		ld_xs   = ld_x;
		ld_ys   = ld_y;
		ld_z    = '0;
		ld_hold = 1'b0;
		if (ld_y == '0) begin
			ld_hold = 1'b1;
			if (ld_x[XY_W-1])
				ld_z = Z_180;
		end else if (ld_x[XY_W-1]) begin
			ld_z  = ld_y[XY_W-1] ? -Z_180 : Z_180;
			ld_xs = -ld_x;
			ld_ys = -ld_y;
		end
	end

	// one micro-rotation per cycle
	assign x_shift = cx_q >>> ccnt_q;
	assign y_shift = cy_q >>> ccnt_q;
	assign at_step = signed'(Z_W'(tcf_pkg::atan_q16(tcf_pkg::ATAN_IDX_W'(ccnt_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ccnt_q <= CNT_W'(CORDIC_STEPS);
		else if (cordic_load)
			ccnt_q <= ld_hold ? CNT_W'(CORDIC_STEPS) : '0;
		else if (cordic_run)
			ccnt_q <= ccnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cordic_load) begin
			cx_q <= ld_xs;
			cy_q <= ld_ys;
			cz_q <= ld_z;
		end else if (cordic_run) begin
			if (!cy_q[XY_W-1]) begin
				cx_q <= cx_q + y_shift;
				cy_q <= cy_q - x_shift;
				cz_q <= cz_q + at_step;
			end else begin
				cx_q <= cx_q - y_shift;
				cy_q <= cy_q + x_shift;
				cz_q <= cz_q - at_step;
			end
		end
	end

	// blend rounding and saturation
	assign acc_rnd  = acc_q + ACC_RND;
	assign res_wide = signed'(acc_rnd[ACC_W-1:32]);

	always_comb begin
		if (res_wide > RES_MAX)
			fused_sat = 16'sh7fff;
		else if (res_wide < RES_MIN)
			fused_sat = 16'sh8000;
		else
			fused_sat = 16'(res_wide);
	end

	// filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				filt_q      <= fused_sat;
				out_valid_q <= 1'b1;
			end else if (angles.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_roll_q  <= roll_q;
			out_pitch_q <= pitch_q;
			out_fused_q <= fused_sat;
		end
	end

	assign angles.valid       = out_valid_q;
	assign angles.roll_angle  = out_roll_q;
	assign angles.pitch_angle = out_pitch_q;
	assign angles.fused_angle = out_fused_q;

endmodule
`default_nettype wire
